// ===== hw/rtl/cts_pkg.sv =====
// cts_pkg: shared types, command codes and limits for the task table scheduler
// used by cts_slot_unit and cooperative_task_table_scheduler; no dependencies
`default_nettype none

package cts_pkg;

  localparam int TASK_SLOTS_DEFAULT = 16;
  localparam int RESULT_LIMIT       = 16;
  localparam int COUNT_W            = $clog2(RESULT_LIMIT + 1);

  // command codes, also used as result kinds
  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_DELETE   = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;
  localparam logic [1:0] CMD_DISPATCH = 2'd3;

  localparam logic [7:0]  RUNS_MAX  = 8'hFF;
  localparam logic [31:0] IDENT_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] IDENT_ONE = 32'd1;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  runs;
    logic [31:0] ident;
  } slot_rec_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] handle;
    logic [15:0] start_delay;
    logic [15:0] repeat_period;
    logic [31:0] task_id;
  } cmd_rec_t;

  typedef struct packed {
    logic      wr_en;
    logic      occ_next;
    logic      hit;
    slot_rec_t rec;
  } slot_upd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cts_slot_unit.sv =====
// cts_slot_unit: update logic applied to one slot record per cycle
// depends on cts_pkg
`default_nettype none

module cts_slot_unit (
  input  var cts_pkg::cmd_rec_t  cmd,
  input  var cts_pkg::slot_rec_t rec,
  input  wire                    occ,
  input  wire                    found,
  input  wire                    limit,
  input  wire [31:0]             next_ident,
  output cts_pkg::slot_upd_t     upd
);

  always_comb begin
    upd          = '0;
    upd.rec      = rec;
    upd.occ_next = occ;
    case (cmd.command)
      cts_pkg::CMD_ADD: begin
        if (!found && cmd.handle != 16'd0 && !occ) begin
          upd.wr_en      = 1'b1;
          upd.occ_next   = 1'b1;
          upd.hit        = 1'b1;
          upd.rec.handle = cmd.handle;
          upd.rec.delay  = cmd.start_delay;
          upd.rec.period = cmd.repeat_period;
          upd.rec.runs   = 8'd0;
          upd.rec.ident  = next_ident;
        end
      end
      cts_pkg::CMD_DELETE: begin
        if (!found && cmd.task_id != 32'd0 && occ && rec.ident == cmd.task_id) begin
          upd.occ_next = 1'b0;
          upd.hit      = 1'b1;
        end
      end
      cts_pkg::CMD_TICK: begin
        if (occ) begin
          upd.wr_en = 1'b1;
          if (rec.delay == 16'd0) begin
            if (rec.runs != cts_pkg::RUNS_MAX) upd.rec.runs = rec.runs + 8'd1;
            if (rec.period != 16'd0) upd.rec.delay = rec.period;
          end else begin
            upd.rec.delay = rec.delay - 16'd1;
          end
        end
      end
      cts_pkg::CMD_DISPATCH: begin
        if (occ && rec.runs != 8'd0 && !limit) begin
          upd.wr_en    = 1'b1;
          upd.hit      = 1'b1;
          upd.rec.runs = rec.runs - 8'd1;
          // one-shot task leaves the table after its run
          if (rec.period == 16'd0) upd.occ_next = 1'b0;
        end
      end
      default: begin
        upd.wr_en = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cooperative_task_table_scheduler.sv =====
// cooperative_task_table_scheduler: top level, slot memory, walk sequencer, result register
// depends on cts_pkg and cts_slot_unit
//
//  channel   signals                                                   handshake
//  command   command handle start_delay repeat_period task_id          start && !busy
//  result    kind ok result_id run_handle last                         strobe, one cycle
//
// every command walks all TASK_SLOTS slots through one shared update unit: the idle state
// accepts, a read-ahead fetches the first slot, each slot is read through the single
// read port of the slot memory and updated, and the reply state registers the final
// result. busy is high from acceptance until the final result is registered. non-final
// dispatch results come out at most one per cycle during the walk; the receiver cannot
// stall. synchronous reset clears the slot valid bits and control, next_ident to one.
`default_nettype none

module cooperative_task_table_scheduler #(
  parameter int TASK_SLOTS = cts_pkg::TASK_SLOTS_DEFAULT
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire [1:0]  command,
  input  wire [15:0] handle,
  input  wire [15:0] start_delay,
  input  wire [15:0] repeat_period,
  input  wire [31:0] task_id,
  output logic       strobe,
  output logic [1:0] kind,
  output logic       ok,
  output logic [31:0] result_id,
  output logic [15:0] run_handle,
  output logic       last
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TASK_SLOTS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_REPLY = 2'd2;

  logic [1:0]                     state;
  cts_pkg::cmd_rec_t              cmd;
  logic [CNT_W-1:0]               rd_cnt;
  logic [IDX_W-1:0]               rd_idx;
  logic                           p_vld;
  logic [IDX_W-1:0]               p_idx;
  cts_pkg::slot_rec_t             mem [TASK_SLOTS];
  cts_pkg::slot_rec_t             mem_q;
  logic [TASK_SLOTS-1:0]          valid;
  logic                           found;
  logic [31:0]                    res_id;
  logic [31:0]                    next_ident;
  logic [cts_pkg::COUNT_W-1:0]    n_cnt;
  logic                           hold_vld;
  logic [31:0]                    hold_id;
  logic [15:0]                    hold_handle;
  logic                           limit;
  logic                           emit_hit;
  cts_pkg::slot_upd_t             upd;

  assign busy     = (state != ST_IDLE);
  assign rd_idx   = rd_cnt[IDX_W-1:0];
  assign limit    = (n_cnt == cts_pkg::COUNT_W'(cts_pkg::RESULT_LIMIT));
  assign emit_hit = (state == ST_WALK) && p_vld && upd.hit;

  cts_slot_unit u_unit (
    .cmd        (cmd),
    .rec        (mem_q),
    .occ        (valid[p_idx]),
    .found      (found),
    .limit      (limit),
    .next_ident (next_ident),
    .upd        (upd)
  );

  // slot memory: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (state == ST_WALK && rd_cnt != CNT_END) mem_q <= mem[rd_idx];
    if (state == ST_WALK && p_vld && upd.wr_en) mem[p_idx] <= upd.rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (state == ST_WALK && p_vld) begin
      valid[p_idx] <= upd.occ_next;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_cnt     <= '0;
      p_vld      <= 1'b0;
      found      <= 1'b0;
      n_cnt      <= '0;
      hold_vld   <= 1'b0;
      next_ident <= cts_pkg::IDENT_ONE;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state    <= ST_WALK;
            rd_cnt   <= '0;
            p_vld    <= 1'b0;
            found    <= 1'b0;
            n_cnt    <= '0;
            hold_vld <= 1'b0;
          end
        end
        ST_WALK: begin
          if (rd_cnt != CNT_END) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
            p_vld  <= 1'b1;
          end else begin
            p_vld <= 1'b0;
            state <= ST_REPLY;
          end
          if (emit_hit) begin
            found <= 1'b1;
            if (cmd.command == cts_pkg::CMD_ADD) begin
              next_ident <= (next_ident == cts_pkg::IDENT_MAX) ? cts_pkg::IDENT_ONE
                                                               : next_ident + 32'd1;
            end
            if (cmd.command == cts_pkg::CMD_DISPATCH) begin
              n_cnt    <= n_cnt + cts_pkg::COUNT_W'(1);
              hold_vld <= 1'b1;
              // a later hit shows the held run is not the final one
              if (hold_vld) strobe <= 1'b1;
            end
          end
        end
        ST_REPLY: begin
          state  <= ST_IDLE;
          strobe <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd.command       <= command;
      cmd.handle        <= handle;
      cmd.start_delay   <= start_delay;
      cmd.repeat_period <= repeat_period;
      cmd.task_id       <= task_id;
    end
    if (state == ST_WALK) p_idx <= rd_idx;
    if (emit_hit) begin
      res_id      <= next_ident;
      hold_id     <= mem_q.ident;
      hold_handle <= mem_q.handle;
      if (cmd.command == cts_pkg::CMD_DISPATCH && hold_vld) begin
        kind       <= cts_pkg::CMD_DISPATCH;
        ok         <= 1'b1;
        result_id  <= hold_id;
        run_handle <= hold_handle;
        last       <= 1'b0;
      end
    end
    if (state == ST_REPLY) begin
      kind       <= cmd.command;
      last       <= 1'b1;
      run_handle <= 16'd0;
      case (cmd.command)
        cts_pkg::CMD_ADD: begin
          ok        <= found;
          result_id <= found ? res_id : 32'd0;
        end
        cts_pkg::CMD_DELETE: begin
          ok        <= found;
          result_id <= found ? cmd.task_id : 32'd0;
        end
        cts_pkg::CMD_TICK: begin
          ok        <= 1'b1;
          result_id <= 32'd0;
        end
        cts_pkg::CMD_DISPATCH: begin
          ok         <= hold_vld;
          result_id  <= hold_vld ? hold_id : 32'd0;
          run_handle <= hold_vld ? hold_handle : 16'd0;
        end
        default: begin
          ok        <= 1'b0;
          result_id <= 32'd0;
        end
      endcase
    end
  end

  // checks
  a_last_ends_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final result while still busy");

  a_multi_only_dispatch: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> kind == cts_pkg::CMD_DISPATCH && ok)
    else $error("non-final result outside dispatch");

  a_add_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe && ok && kind == cts_pkg::CMD_ADD |-> result_id != 32'd0)
    else $error("add placed with identifier zero");

  a_limit: assert property (@(posedge clk) disable iff (rst)
    n_cnt <= cts_pkg::COUNT_W'(cts_pkg::RESULT_LIMIT))
    else $error("dispatch result count beyond limit");

  a_ident_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_ident != 32'd0)
    else $error("identifier counter reached zero");

endmodule

`default_nettype wire
